// ===== hw/rtl/nbc_pkg.sv =====
// shared types and constants of the newline block chunker
`default_nettype none
package nbc_pkg;

   localparam int unsigned BLOCK_MAX = 1048576;
   localparam int unsigned IDX_W     = $clog2(BLOCK_MAX) + 1;
   localparam int unsigned CNT_W     = 32;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [1:0] {
      ACT_SPLIT_LAST       = 2'd0,
      ACT_COMPLETE_PARTIAL = 2'd1,
      ACT_COMPLETE_FINAL   = 2'd2,
      ACT_SKIP_ROWS        = 2'd3
   } action_type;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             block_end;
      logic [1:0]       action;
      logic             partial_empty;
      logic             final_block;
      logic [CNT_W-1:0] skip_count;
   } item_type;

   typedef struct packed {
      logic [1:0]       action;
      logic             partial_empty;
      logic             final_block;
      logic [CNT_W-1:0] skip_count;
   } mode_type;

   typedef struct packed {
      logic [IDX_W-1:0] cut_pos;
      logic [IDX_W-1:0] rows_found;
      logic [CNT_W-1:0] remaining_count;
      logic             status;
   } result_type;

endpackage
`default_nettype wire

// ===== hw/rtl/nbc_req_if.sv =====
// request channel of the newline block chunker
`default_nettype none
interface nbc_req_if;
   logic                      valid;
   logic                      ready;
   logic [7:0]                data_byte;
   logic                      block_end;
   logic [1:0]                action;
   logic                      partial_empty;
   logic                      final_block;
   logic [nbc_pkg::CNT_W-1:0] skip_count;

   modport source (output valid, data_byte, block_end, action, partial_empty,
                   final_block, skip_count, input ready);
   modport sink (input valid, data_byte, block_end, action, partial_empty,
                 final_block, skip_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/nbc_rsp_if.sv =====
// result channel of the newline block chunker
`default_nettype none
interface nbc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nbc_pkg::IDX_W-1:0] cut_pos;
   logic [nbc_pkg::IDX_W-1:0] rows_found;
   logic [nbc_pkg::CNT_W-1:0] remaining_count;
   logic                      status;

   modport source (output valid, cut_pos, rows_found, remaining_count, status,
                   input ready);
   modport sink (input valid, cut_pos, rows_found, remaining_count, status,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/nbc_scan.sv =====
// per-block scan state and cut position logic
`default_nettype none
module nbc_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire nbc_pkg::item_type  item,
   output nbc_pkg::result_type     result
);

   localparam int unsigned IW = nbc_pkg::IDX_W;
   localparam int unsigned CW = nbc_pkg::CNT_W;

   logic [IW-1:0] byte_index_ff, byte_index_in;
   logic          any_delim_ff, any_delim_in;
   logic [IW-1:0] first_run_end_ff, first_run_end_in;
   logic          first_run_open_ff, first_run_open_in;
   logic [IW-1:0] last_delim_end_ff, last_delim_end_in;
   logic [IW-1:0] newlines_ff, newlines_in;
   logic [IW-1:0] nth_end_ff, nth_end_in;
   logic          nth_reached_ff, nth_reached_in;
   logic          prev_cr_ff, prev_cr_in;
   nbc_pkg::mode_type mode_ff, mode_in;

   always_comb begin
      logic [IW-1:0] idx_next;
      logic          is_cr;
      logic          is_lf;
      logic [IW-1:0] rows;
      logic [IW-1:0] cut;
      logic [CW-1:0] rows_ext;
      logic          status;

      // mode is taken from the first byte of a block
      if (byte_index_ff == '0) begin
         mode_in.action        = item.action;
         mode_in.partial_empty = item.partial_empty;
         mode_in.final_block   = item.final_block;
         mode_in.skip_count    = item.skip_count;
      end else begin
         mode_in = mode_ff;
      end

      byte_index_in     = byte_index_ff;
      any_delim_in      = any_delim_ff;
      first_run_end_in  = first_run_end_ff;
      first_run_open_in = first_run_open_ff;
      last_delim_end_in = last_delim_end_ff;
      newlines_in       = newlines_ff;
      nth_end_in        = nth_end_ff;
      nth_reached_in    = nth_reached_ff;
      prev_cr_in        = prev_cr_ff;

      idx_next = byte_index_ff + IW'(1);
      is_cr    = (item.data_byte == nbc_pkg::CHAR_CR);
      is_lf    = (item.data_byte == nbc_pkg::CHAR_LF);

      // bytes past the block limit are dropped
      if (byte_index_ff < IW'(nbc_pkg::BLOCK_MAX)) begin
         if (is_cr || is_lf) begin
            if (!any_delim_ff) begin
               any_delim_in      = 1'b1;
               first_run_open_in = 1'b1;
            end
            if (first_run_open_in) begin
               first_run_end_in = idx_next;
            end
            last_delim_end_in = idx_next;
            if (is_lf && prev_cr_ff) begin
               // lf closing a crlf already counted
               nth_end_in = idx_next;
               prev_cr_in = 1'b0;
            end else if (!nth_reached_ff) begin
               newlines_in    = newlines_ff + IW'(1);
               nth_end_in     = idx_next;
               nth_reached_in = ({{(CW-IW){1'b0}}, newlines_in} >= mode_in.skip_count);
               prev_cr_in     = is_cr;
            end else begin
               prev_cr_in = 1'b0;
            end
         end else begin
            first_run_open_in = 1'b0;
            prev_cr_in        = 1'b0;
         end
         byte_index_in = idx_next;
      end

      cut      = '0;
      rows     = '0;
      rows_ext = '0;
      status   = 1'b0;
      result.remaining_count = '0;
      case (mode_in.action)
         nbc_pkg::ACT_SPLIT_LAST: begin
            cut = any_delim_in ? last_delim_end_in : '0;
         end
         nbc_pkg::ACT_COMPLETE_PARTIAL, nbc_pkg::ACT_COMPLETE_FINAL: begin
            if (mode_in.partial_empty) begin
               cut = '0;
            end else if (any_delim_in) begin
               cut = first_run_end_in;
            end else if (mode_in.action == nbc_pkg::ACT_COMPLETE_PARTIAL) begin
               status = 1'b1;
            end else begin
               cut = byte_index_in;
            end
         end
         default: begin
            if (newlines_in == '0) begin
               status = 1'b1;
               result.remaining_count = mode_in.skip_count;
            end else begin
               rows = newlines_in;
               cut  = nth_end_in;
               // unterminated last row of the final block
               if (mode_in.final_block &&
                   (mode_in.skip_count > {{(CW-IW){1'b0}}, newlines_in}) &&
                   (nth_end_in != byte_index_in)) begin
                  rows = newlines_in + IW'(1);
                  cut  = byte_index_in;
               end
               rows_ext = {{(CW-IW){1'b0}}, rows};
               result.remaining_count = (mode_in.skip_count > rows_ext) ?
                                        mode_in.skip_count - rows_ext : '0;
            end
         end
      endcase
      result.cut_pos    = cut;
      result.rows_found = rows;
      result.status     = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff     <= '0;
         any_delim_ff      <= 1'b0;
         first_run_end_ff  <= '0;
         first_run_open_ff <= 1'b0;
         last_delim_end_ff <= '0;
         newlines_ff       <= '0;
         nth_end_ff        <= '0;
         nth_reached_ff    <= 1'b0;
         prev_cr_ff        <= 1'b0;
      end else if (advance) begin
         if (item.block_end) begin
            byte_index_ff     <= '0;
            any_delim_ff      <= 1'b0;
            first_run_end_ff  <= '0;
            first_run_open_ff <= 1'b0;
            last_delim_end_ff <= '0;
            newlines_ff       <= '0;
            nth_end_ff        <= '0;
            nth_reached_ff    <= 1'b0;
            prev_cr_ff        <= 1'b0;
         end else begin
            byte_index_ff     <= byte_index_in;
            any_delim_ff      <= any_delim_in;
            first_run_end_ff  <= first_run_end_in;
            first_run_open_ff <= first_run_open_in;
            last_delim_end_ff <= last_delim_end_in;
            newlines_ff       <= newlines_in;
            nth_end_ff        <= nth_end_in;
            nth_reached_ff    <= nth_reached_in;
            prev_cr_ff        <= prev_cr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_ff <= mode_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/nbc_out_reg.sv =====
// result register with valid/ready handshake
`default_nettype none
module nbc_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire nbc_pkg::result_type  result,
   output logic                      free,
   nbc_rsp_if.source                 rsp_chan
);

   logic                valid_ff, valid_in;
   nbc_pkg::result_type data_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.cut_pos         = data_ff.cut_pos;
   assign rsp_chan.rows_found      = data_ff.rows_found;
   assign rsp_chan.remaining_count = data_ff.remaining_count;
   assign rsp_chan.status          = data_ff.status;

endmodule
`default_nettype wire

// ===== hw/rtl/newline_block_chunker_top.sv =====
// top level of the newline block chunker
//
//   channel    dir   payload                                              notes
//   req_chan   in    data_byte block_end action partial_empty             one byte per request
//                    final_block skip_count
//   rsp_chan   out   cut_pos rows_found remaining_count status            one per block end
//
// one byte per cycle sustained while the result register has room at each
// block end; the request register and the scan state update form a single
// pass, so the result register loads as the last byte of a block advances out
// of the request register. reset (synchronous) empties both registers and
// clears the scan state. a stalled result holds the byte at block end in the
// request register, and the request channel stalls until the result register has room
`default_nettype none
module newline_block_chunker_top (
   input  wire logic  clock,
   input  wire logic  reset,
   nbc_req_if.sink    req_chan,
   nbc_rsp_if.source  rsp_chan
);

   logic                in_valid_ff, in_valid_in;
   nbc_pkg::item_type   in_item_ff;
   nbc_pkg::result_type scan_result;
   logic                out_free;
   logic                advance;

   // a block-end byte may only move on when the result register has room
   assign advance        = in_valid_ff && (!in_item_ff.block_end || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff.data_byte     <= req_chan.data_byte;
         in_item_ff.block_end     <= req_chan.block_end;
         in_item_ff.action        <= req_chan.action;
         in_item_ff.partial_empty <= req_chan.partial_empty;
         in_item_ff.final_block   <= req_chan.final_block;
         in_item_ff.skip_count    <= req_chan.skip_count;
      end
   end

   nbc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (scan_result)
   );

   nbc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && in_item_ff.block_end),
      .result   (scan_result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== tb/newline_block_chunker_top_test.sv =====
// testbench of the newline block chunker: directed and random blocks checked against a predictor
`timescale 1ns / 100ps
module newline_block_chunker_top_test;
   import nbc_pkg::*;

   logic clock;
   logic reset = 1'b1;

   nbc_req_if req_chan ();
   nbc_rsp_if rsp_chan ();

   newline_block_chunker_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state, cleared at each block end
   logic [IDX_W-1:0] pos_count;
   logic             seen_delim;
   logic [IDX_W-1:0] lead_run_end;
   logic             lead_run_open;
   logic [IDX_W-1:0] last_break_end;
   logic [IDX_W-1:0] breaks_counted;
   logic [IDX_W-1:0] target_break_end;
   logic             target_hit;
   logic             after_cr;
   mode_type         held_mode;

   result_type pending_cuts[$];
   int         mismatch_count = 0;
   bit         quiet_send = 1'b0;
   bit         quiet_recv = 1'b0;
   int         ready_hold = 0;

   task automatic clear_scan();
      pos_count        = '0;
      seen_delim       = 1'b0;
      lead_run_end     = '0;
      lead_run_open    = 1'b0;
      last_break_end   = '0;
      breaks_counted   = '0;
      target_break_end = '0;
      target_hit       = 1'b0;
      after_cr         = 1'b0;
   endtask

   task automatic predict_cut(input item_type it);
      result_type  r;
      action_type  act;
      logic [32:0] rows;
      logic        is_cr;
      logic        is_lf;
      if (pos_count == 0) begin
         held_mode.action        = it.action;
         held_mode.partial_empty = it.partial_empty;
         held_mode.final_block   = it.final_block;
         held_mode.skip_count    = it.skip_count;
      end
      // bytes past the block limit are dropped from the scan
      if (pos_count < BLOCK_MAX) begin
         is_cr = (it.data_byte == CHAR_CR);
         is_lf = (it.data_byte == CHAR_LF);
         if (is_cr || is_lf) begin
            if (!seen_delim) begin
               seen_delim    = 1'b1;
               lead_run_open = 1'b1;
            end
            if (lead_run_open)
               lead_run_end = pos_count + 1'b1;
            last_break_end = pos_count + 1'b1;
            if (is_lf && after_cr) begin
               // lf closing a crlf already counted
               target_break_end = pos_count + 1'b1;
               after_cr         = 1'b0;
            end else if (!target_hit) begin
               breaks_counted   = breaks_counted + 1'b1;
               target_break_end = pos_count + 1'b1;
               if (breaks_counted >= held_mode.skip_count)
                  target_hit = 1'b1;
               after_cr = is_cr;
            end else begin
               after_cr = 1'b0;
            end
         end else begin
            lead_run_open = 1'b0;
            after_cr      = 1'b0;
         end
         pos_count = pos_count + 1'b1;
      end
      if (!it.block_end)
         return;
      r    = '0;
      rows = '0;
      act  = action_type'(held_mode.action);
      case (act)
         ACT_SPLIT_LAST: begin
            r.cut_pos = seen_delim ? last_break_end : '0;
         end
         ACT_COMPLETE_PARTIAL, ACT_COMPLETE_FINAL: begin
            if (held_mode.partial_empty)
               r.cut_pos = '0;
            else if (seen_delim)
               r.cut_pos = lead_run_end;
            else if (act == ACT_COMPLETE_PARTIAL)
               r.status = 1'b1;
            else
               r.cut_pos = pos_count;
         end
         default: begin
            if (breaks_counted == 0) begin
               r.status          = 1'b1;
               r.remaining_count = held_mode.skip_count;
            end else begin
               rows      = breaks_counted;
               r.cut_pos = target_break_end;
               // final block adds the unterminated tail row
               if (held_mode.final_block && held_mode.skip_count > rows &&
                   target_break_end != pos_count) begin
                  rows      = rows + 1'b1;
                  r.cut_pos = pos_count;
               end
               r.rows_found      = rows[IDX_W-1:0];
               r.remaining_count = (held_mode.skip_count > rows) ?
                                   held_mode.skip_count - rows[31:0] : '0;
            end
         end
      endcase
      pending_cuts.push_back(r);
      clear_scan();
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_req(input item_type it);
      int gap;
      gap = 0;
      if (!quiet_send && $urandom_range(0, 2) == 0)
         gap = gap_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= it.data_byte;
      req_chan.block_end     <= it.block_end;
      req_chan.action        <= it.action;
      req_chan.partial_empty <= it.partial_empty;
      req_chan.final_block   <= it.final_block;
      req_chan.skip_count    <= it.skip_count;
      do
         @(posedge clock);
      while (!req_chan.ready);
      predict_cut(it);
   endtask

   task automatic send_block(input logic [7:0] chars[$], input action_type act,
                             input logic pe, input logic fin, input logic [31:0] cnt);
      item_type it;
      for (int i = 0; i < chars.size(); i++) begin
         it.data_byte  = chars[i];
         it.block_end  = (i == chars.size() - 1);
         // only the first byte's mode fields matter
         if (i == 0) begin
            it.action        = act;
            it.partial_empty = pe;
            it.final_block   = fin;
            it.skip_count    = cnt;
         end else begin
            it.action        = 2'($urandom_range(0, 3));
            it.partial_empty = 1'($urandom_range(0, 1));
            it.final_block   = 1'($urandom_range(0, 1));
            it.skip_count    = $urandom;
         end
         send_req(it);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100)
         $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_cuts.size() == 0) begin
            report_mismatch("result with no block end pending");
         end else begin
            want = pending_cuts.pop_front();
            if (rsp_chan.cut_pos !== want.cut_pos)
               report_mismatch($sformatf("cut_pos %0d, expected %0d",
                                         rsp_chan.cut_pos, want.cut_pos));
            if (rsp_chan.rows_found !== want.rows_found)
               report_mismatch($sformatf("rows_found %0d, expected %0d",
                                         rsp_chan.rows_found, want.rows_found));
            if (rsp_chan.remaining_count !== want.remaining_count)
               report_mismatch($sformatf("remaining_count %0d, expected %0d",
                                         rsp_chan.remaining_count,
                                         want.remaining_count));
            if (rsp_chan.status !== want.status)
               report_mismatch($sformatf("status %0b, expected %0b",
                                         rsp_chan.status, want.status));
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 299) == 0)
            quiet_recv = !quiet_recv;
         if (ready_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            ready_hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet_recv && $urandom_range(0, 3) == 0)
               ready_hold = gap_len();
         end
      end
   end

   task automatic test_split_last();
      send_block('{8'h61}, ACT_SPLIT_LAST, 1'b0, 1'b0, 32'd1);
      send_block('{8'h61, CHAR_LF, 8'h62, CHAR_CR, 8'h63}, ACT_SPLIT_LAST, 1'b1, 1'b1,
                 32'd0);
      send_block('{CHAR_CR}, ACT_SPLIT_LAST, 1'b0, 1'b0, 32'hFFFF_FFFF);
      send_block('{8'h00, 8'hFF}, ACT_SPLIT_LAST, 1'b0, 1'b1, 32'd7);
   endtask

   task automatic test_complete_rows();
      send_block('{8'h61, 8'h62}, ACT_COMPLETE_PARTIAL, 1'b0, 1'b0, 32'd1);
      send_block('{8'h61, 8'h62}, ACT_COMPLETE_FINAL, 1'b0, 1'b1, 32'd1);
      send_block('{8'h61, CHAR_LF}, ACT_COMPLETE_PARTIAL, 1'b1, 1'b0, 32'd1);
      send_block('{CHAR_CR, CHAR_LF, 8'h78, CHAR_LF}, ACT_COMPLETE_FINAL, 1'b0, 1'b0,
                 32'd2);
      send_block('{8'h78, CHAR_LF, CHAR_LF, 8'h79}, ACT_COMPLETE_PARTIAL, 1'b0, 1'b0,
                 32'd1);
   endtask

   task automatic test_skip_rows();
      send_block('{8'h61, CHAR_CR, CHAR_LF, 8'h62, CHAR_LF, 8'h63}, ACT_SKIP_ROWS, 1'b0,
                 1'b0, 32'd2);
      send_block('{8'h61, 8'h62}, ACT_SKIP_ROWS, 1'b0, 1'b1, 32'd1);
      send_block('{8'h61, CHAR_LF, 8'h62}, ACT_SKIP_ROWS, 1'b0, 1'b1, 32'd5);
      send_block('{CHAR_LF, CHAR_LF}, ACT_SKIP_ROWS, 1'b1, 1'b0, 32'd0);
      send_block('{CHAR_CR, CHAR_CR, CHAR_LF, CHAR_LF}, ACT_SKIP_ROWS, 1'b0, 1'b1,
                 32'hFFFF_FFFF);
      send_block('{CHAR_LF, CHAR_CR}, ACT_SKIP_ROWS, 1'b0, 1'b0, 32'd3);
   endtask

   task automatic test_random_blocks();
      logic [7:0]  chars[$];
      int          bytes_sent;
      int          len;
      int          pick;
      logic [31:0] cnt;
      bytes_sent = 0;
      while (bytes_sent < 2000) begin
         chars.delete();
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                           : $urandom_range(1, 24);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
               chars.push_back(CHAR_LF);
            else if (pick < 3)
               chars.push_back(CHAR_CR);
            else if (pick < 4)
               chars.push_back(8'($urandom_range(0, 255)));
            else
               chars.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end
         pick = $urandom_range(0, 19);
         if (pick == 0)
            cnt = 32'd0;
         else if (pick == 1)
            cnt = 32'hFFFF_FFFF;
         else if (pick < 4)
            cnt = $urandom;
         else
            cnt = $urandom_range(1, 6);
         quiet_send = ($urandom_range(0, 4) == 0);
         send_block(chars, action_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), cnt);
         bytes_sent += len;
      end
      quiet_send = 1'b0;
   endtask

   initial begin
      req_chan.valid         = 1'b0;
      req_chan.data_byte     = '0;
      req_chan.block_end     = 1'b0;
      req_chan.action        = '0;
      req_chan.partial_empty = 1'b0;
      req_chan.final_block   = 1'b0;
      req_chan.skip_count    = '0;
      clear_scan();
      held_mode = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_split_last();
      test_complete_rows();
      test_skip_rows();
      test_random_blocks();
      req_chan.valid <= 1'b0;
      while (pending_cuts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("newline_block_chunker_top: match");
      else
         $display("newline_block_chunker_top: mismatch");
      $finish;
   end

   initial begin
      #200000000;
      $display("newline_block_chunker_top: mismatch");
      $finish;
   end

endmodule

// ===== newline_block_chunker_top.f =====
hw/rtl/nbc_pkg.sv
hw/rtl/nbc_req_if.sv
hw/rtl/nbc_rsp_if.sv
hw/rtl/nbc_scan.sv
hw/rtl/nbc_out_reg.sv
hw/rtl/newline_block_chunker_top.sv
tb/newline_block_chunker_top_test.sv
